### design/wrrtt_pkg.sv
package wrrtt_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MaxTasksDef   = 16;
  localparam int unsigned IdBitsDef     = 8;
  localparam int unsigned WeightBitsDef = 8;

  // Fixed payload widths
  localparam int unsigned ReqTypeW    = 2;
  localparam int unsigned TaskIdW     = 8;
  localparam int unsigned WeightInW   = 8;
  localparam int unsigned StatusW     = 3;
  localparam int unsigned GrantIdW    = 8;
  localparam int unsigned GrantTimesW = 32;
  localparam int unsigned ActiveW     = 5;

  typedef enum logic [ReqTypeW-1:0] {
    REQ_ADD        = 2'd0,
    REQ_REMOVE     = 2'd1,
    REQ_SET_WEIGHT = 2'd2,
    REQ_GRANT      = 2'd3
  } req_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK        = 3'd0,
    STATUS_DUPLICATE = 3'd1,
    STATUS_NOT_FOUND = 3'd2,
    STATUS_FULL      = 3'd3,
    STATUS_EMPTY     = 3'd4
  } status_e;

  // Control handed from the sequencer to the head of the slot chain
  typedef struct packed {
    req_e op;
    logic in_range;  // slot at the head is occupied
    logic done;      // match or grant already seen in this request
    logic walk;      // grant walk has reached the cursor
    logic append;    // head position is the first free slot
  } head_ctl_t;

endpackage

### design/wrrtt_if.sv
interface wrrtt_req_if;
  logic                               valid;
  logic                               ready;
  logic [wrrtt_pkg::ReqTypeW-1:0]     req_type;
  logic [wrrtt_pkg::TaskIdW-1:0]      task_id;
  logic [wrrtt_pkg::WeightInW-1:0]    weight_in;

  modport source (output valid, req_type, task_id, weight_in, input ready);
  modport sink   (input valid, req_type, task_id, weight_in, output ready);
endinterface

interface wrrtt_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [wrrtt_pkg::StatusW-1:0]       status;
  logic                                grant_valid;
  logic [wrrtt_pkg::GrantIdW-1:0]      grant_id;
  logic [wrrtt_pkg::GrantTimesW-1:0]   grant_times;
  logic [wrrtt_pkg::ActiveW-1:0]       active_tasks;

  modport source (output valid, status, grant_valid, grant_id, grant_times, active_tasks,
                  input ready);
  modport sink   (input valid, status, grant_valid, grant_id, grant_times, active_tasks,
                  output ready);
endinterface

### design/weighted_round_robin_task_table.sv
// Weighted round-robin task table. The slots form a ring of MAX_TASKS cells
// that turns one position per cycle past a single head unit while a request
// walks. Add, remove, set weight and a grant on an empty table each take one
// full turn of the ring between acceptance in the idle state and the hand-off
// of the result from the send state to the output register.
// A grant keeps turning the ring in full turns until a slot with a zero skip
// counter comes by; slots before the cursor are skipped in the first turn.
// Requests are taken one at a time; a result waiting on the output does not
// hold off the next request from being taken and walked, but that request
// waits in the send state until the output register frees, which adds the
// output stall to it.
module weighted_round_robin_task_table #(
  parameter int unsigned MAX_TASKS   = wrrtt_pkg::MaxTasksDef,
  parameter int unsigned ID_BITS     = wrrtt_pkg::IdBitsDef,
  parameter int unsigned WEIGHT_BITS = wrrtt_pkg::WeightBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  wrrtt_req_if.sink          req_i,
  wrrtt_rsp_if.source        rsp_o
);

  localparam int unsigned SlotW = ID_BITS + 2 * WEIGHT_BITS + wrrtt_pkg::GrantTimesW;
  localparam int unsigned KW    = $clog2(MAX_TASKS);
  localparam int unsigned CW    = $clog2(MAX_TASKS + 1);
  localparam logic [16:0] WeightMax = 17'((2 ** WEIGHT_BITS) - 1);

  typedef enum logic [2:0] {
    SM_IDLE = 3'b001,
    SM_WALK = 3'b010,
    SM_SEND = 3'b100
  } state_e;

  state_e                            state_q;
  wrrtt_pkg::req_e                   op_q;
  logic [ID_BITS-1:0]                key_q;
  logic [WEIGHT_BITS-1:0]            wt_q;
  logic [KW-1:0]                     k_q;
  logic                              first_q, found_q;
  logic [CW-1:0]                     cnt_q, cur_q, gcur_q;
  logic [ID_BITS-1:0]                gid_q;
  logic [wrrtt_pkg::GrantTimesW-1:0] gtimes_q;
  logic                              gval_q;
  wrrtt_pkg::status_e                stat_q;

  logic                              rsp_valid_q, rsp_gval_q;
  logic [wrrtt_pkg::StatusW-1:0]     rsp_status_q;
  logic [wrrtt_pkg::GrantIdW-1:0]    rsp_gid_q;
  logic [wrrtt_pkg::GrantTimesW-1:0] rsp_gtimes_q;
  logic [wrrtt_pkg::ActiveW-1:0]     rsp_active_q;

  logic [SlotW-1:0]                  slot_q [MAX_TASKS];
  logic [SlotW-1:0]                  tail;
  logic                              hit, walking, last, found_now, finish, req_xfer, rsp_load;
  logic [ID_BITS-1:0]                head_gid;
  logic [wrrtt_pkg::GrantTimesW-1:0] head_gtimes;
  logic [CW-1:0]                     k_ext, cur_eff, cnt_dec;
  wrrtt_pkg::head_ctl_t              ctl;
  logic [16:0]                       w_ext, w_sat;
  logic [39:0]                       id_ext, gid_ext;
  logic [8:0]                        cnt_ext;

  // Slot ring
  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    logic [SlotW-1:0] nbr;
    if (i == MAX_TASKS - 1) begin : g_tail
      assign nbr = tail;
    end else begin : g_mid
      assign nbr = slot_q[i+1];
    end
    wrrtt_cell #(.SlotW(SlotW)) u_cell (
      .clk_i  (clk_i),
      .shift_i(walking),
      .slot_i (nbr),
      .slot_o (slot_q[i])
    );
  end

  wrrtt_head #(
    .ID_BITS    (ID_BITS),
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_head (
    .ctl_i        (ctl),
    .key_i        (key_q),
    .weight_i     (wt_q),
    .head_i       (slot_q[0]),
    .next_i       (slot_q[1]),
    .tail_o       (tail),
    .hit_o        (hit),
    .grant_id_o   (head_gid),
    .grant_times_o(head_gtimes)
  );

  assign walking   = (state_q == SM_WALK);
  assign req_xfer  = req_i.valid && req_i.ready;
  assign rsp_load  = (state_q == SM_SEND) && (!rsp_valid_q || rsp_o.ready);
  assign last      = (k_q == KW'(MAX_TASKS - 1));
  assign k_ext     = CW'(k_q);
  assign cur_eff   = (cur_q >= cnt_q) ? '0 : cur_q;
  assign found_now = found_q || hit;
  assign cnt_dec   = cnt_q - CW'(1);
  assign finish    = walking && last &&
                     ((op_q != wrrtt_pkg::REQ_GRANT) || found_now || (cnt_q == '0));

  always_comb begin
    ctl.op       = op_q;
    ctl.in_range = (k_ext < cnt_q);
    ctl.done     = found_q;
    ctl.walk     = !first_q || (k_ext >= cur_eff);
    ctl.append   = (k_ext == cnt_q) && !found_q;
  end

  // Weight clamp and id trim at the input
  always_comb begin
    w_ext  = 17'(req_i.weight_in);
    w_sat  = (w_ext == '0) ? 17'd1 : ((w_ext > WeightMax) ? WeightMax : w_ext);
    id_ext = 40'(req_i.task_id);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SM_IDLE;
      cnt_q       <= '0;
      cur_q       <= '0;
      k_q         <= '0;
      first_q     <= 1'b0;
      found_q     <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        SM_IDLE: begin
          if (req_xfer) begin
            k_q     <= '0;
            first_q <= 1'b1;
            found_q <= 1'b0;
            state_q <= SM_WALK;
          end
        end
        SM_WALK: begin
          k_q     <= last ? '0 : k_q + KW'(1);
          found_q <= found_now;
          if (last) begin
            first_q <= 1'b0;
          end
          if (finish) begin
            state_q <= SM_SEND;
            unique case (op_q)
              wrrtt_pkg::REQ_ADD: begin
                if (!found_now && (cnt_q != CW'(MAX_TASKS))) begin
                  cnt_q <= cnt_q + CW'(1);
                end
              end
              wrrtt_pkg::REQ_REMOVE: begin
                if (found_now) begin
                  cnt_q <= cnt_dec;
                  if (cur_q >= cnt_dec) begin
                    cur_q <= '0;
                  end
                end
              end
              wrrtt_pkg::REQ_SET_WEIGHT: begin
              end
              wrrtt_pkg::REQ_GRANT: begin
                if (hit) begin
                  cur_q <= k_ext + CW'(1);
                end else if (found_q) begin
                  cur_q <= gcur_q;
                end
              end
            endcase
          end
        end
        SM_SEND: begin
          if (rsp_load) begin
            state_q <= SM_IDLE;
          end
        end
        default: state_q <= SM_IDLE;
      endcase

      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      op_q  <= wrrtt_pkg::req_e'(req_i.req_type);
      key_q <= id_ext[ID_BITS-1:0];
      wt_q  <= w_sat[WEIGHT_BITS-1:0];
    end
    if (walking && hit && (op_q == wrrtt_pkg::REQ_GRANT)) begin
      gid_q    <= head_gid;
      gtimes_q <= head_gtimes;
      gcur_q   <= k_ext + CW'(1);
    end
    if (finish) begin
      gval_q <= (op_q == wrrtt_pkg::REQ_GRANT) && found_now;
      unique case (op_q)
        wrrtt_pkg::REQ_ADD: begin
          if (found_now) begin
            stat_q <= wrrtt_pkg::STATUS_DUPLICATE;
          end else if (cnt_q == CW'(MAX_TASKS)) begin
            stat_q <= wrrtt_pkg::STATUS_FULL;
          end else begin
            stat_q <= wrrtt_pkg::STATUS_OK;
          end
        end
        wrrtt_pkg::REQ_REMOVE, wrrtt_pkg::REQ_SET_WEIGHT: begin
          stat_q <= found_now ? wrrtt_pkg::STATUS_OK : wrrtt_pkg::STATUS_NOT_FOUND;
        end
        wrrtt_pkg::REQ_GRANT: begin
          stat_q <= (cnt_q == '0) ? wrrtt_pkg::STATUS_EMPTY : wrrtt_pkg::STATUS_OK;
        end
      endcase
    end
    if (rsp_load) begin
      rsp_status_q <= stat_q;
      rsp_gval_q   <= gval_q;
      rsp_gid_q    <= gval_q ? gid_ext[wrrtt_pkg::GrantIdW-1:0] : '0;
      rsp_gtimes_q <= gval_q ? gtimes_q : '0;
      rsp_active_q <= cnt_ext[wrrtt_pkg::ActiveW-1:0];
    end
  end

  assign gid_ext = 40'(gid_q);
  assign cnt_ext = 9'(cnt_q);

  assign req_i.ready        = (state_q == SM_IDLE);
  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = rsp_status_q;
  assign rsp_o.grant_valid  = rsp_gval_q;
  assign rsp_o.grant_id     = rsp_gid_q;
  assign rsp_o.grant_times  = rsp_gtimes_q;
  assign rsp_o.active_tasks = rsp_active_q;

endmodule

### design/wrrtt_cell.sv
// One table slot; takes its neighbor's slot on every shift.
module wrrtt_cell #(
  parameter int unsigned SlotW = 1
) (
  input  logic             clk_i,
  input  logic             shift_i,
  input  logic [SlotW-1:0] slot_i,
  output logic [SlotW-1:0] slot_o
);

  logic [SlotW-1:0] slot_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      slot_q <= slot_i;
    end
  end

  assign slot_o = slot_q;

endmodule

### design/wrrtt_head.sv
// Works on the slot leaving the head of the chain and builds the slot that
// enters at the tail. Removal takes the second cell instead of the first, which
// closes the gap as the ring turns.
module wrrtt_head #(
  parameter int unsigned ID_BITS     = wrrtt_pkg::IdBitsDef,
  parameter int unsigned WEIGHT_BITS = wrrtt_pkg::WeightBitsDef,
  localparam int unsigned SlotW      = ID_BITS + 2 * WEIGHT_BITS + wrrtt_pkg::GrantTimesW
) (
  input  wrrtt_pkg::head_ctl_t                 ctl_i,
  input  logic [ID_BITS-1:0]                   key_i,
  input  logic [WEIGHT_BITS-1:0]               weight_i,
  input  logic [SlotW-1:0]                     head_i,
  input  logic [SlotW-1:0]                     next_i,
  output logic [SlotW-1:0]                     tail_o,
  output logic                                 hit_o,
  output logic [ID_BITS-1:0]                   grant_id_o,
  output logic [wrrtt_pkg::GrantTimesW-1:0]    grant_times_o
);

  typedef struct packed {
    logic [ID_BITS-1:0]                id;
    logic [WEIGHT_BITS-1:0]            weight;
    logic [WEIGHT_BITS-1:0]            skip;
    logic [wrrtt_pkg::GrantTimesW-1:0] grants;
  } slot_t;

  slot_t head, nxt, tail;
  logic  match;

  always_comb begin
    head  = slot_t'(head_i);
    nxt   = slot_t'(next_i);
    tail  = head;
    hit_o = 1'b0;
    match = ctl_i.in_range && !ctl_i.done && (head.id == key_i);
    unique case (ctl_i.op)
      wrrtt_pkg::REQ_ADD: begin
        hit_o = match;
        if (ctl_i.append) begin
          tail.id     = key_i;
          tail.weight = weight_i;
          tail.skip   = '0;
          tail.grants = '0;
        end
      end
      wrrtt_pkg::REQ_REMOVE: begin
        hit_o = match;
        if (ctl_i.done || match) begin
          tail = nxt;
        end
      end
      wrrtt_pkg::REQ_SET_WEIGHT: begin
        hit_o = match;
        if (match) begin
          tail.weight = weight_i;
        end
      end
      wrrtt_pkg::REQ_GRANT: begin
        if (ctl_i.in_range && !ctl_i.done && ctl_i.walk) begin
          if (head.skip != '0) begin
            tail.skip = head.skip - WEIGHT_BITS'(1);
          end else begin
            tail.skip   = head.weight - WEIGHT_BITS'(1);
            tail.grants = head.grants + wrrtt_pkg::GrantTimesW'(1);
            hit_o       = 1'b1;
          end
        end
      end
    endcase
  end

  assign tail_o        = SlotW'(tail);
  assign grant_id_o    = head.id;
  assign grant_times_o = head.grants + wrrtt_pkg::GrantTimesW'(1);

endmodule

### design/wrrtt_checker.sv
module wrrtt_props (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                req_valid_i,
  input logic                                req_ready_i,
  input logic                                rsp_valid_i,
  input logic                                rsp_ready_i,
  input logic [wrrtt_pkg::StatusW-1:0]       status_i,
  input logic                                grant_valid_i,
  input logic [wrrtt_pkg::GrantIdW-1:0]      grant_id_i,
  input logic [wrrtt_pkg::GrantTimesW-1:0]   grant_times_i,
  input logic [wrrtt_pkg::ActiveW-1:0]       active_tasks_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(status_i) &&
      $stable(grant_valid_i) && $stable(grant_id_i) && $stable(grant_times_i) &&
      $stable(active_tasks_i))
    else $error("response changed while stalled");

  // One request in flight: the input closes right after a transfer
  a_req_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while busy");

  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && grant_valid_i |->
      status_i == wrrtt_pkg::STATUS_OK && active_tasks_i != '0)
    else $error("grant with bad status or empty table");

  a_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !grant_valid_i |-> grant_id_i == '0 && grant_times_i == '0)
    else $error("grant data without grant");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == wrrtt_pkg::STATUS_EMPTY |->
      active_tasks_i == '0 && !grant_valid_i)
    else $error("empty status with tasks present");

endmodule

bind weighted_round_robin_task_table wrrtt_props u_wrrtt_props (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .status_i      (rsp_o.status),
  .grant_valid_i (rsp_o.grant_valid),
  .grant_id_i    (rsp_o.grant_id),
  .grant_times_i (rsp_o.grant_times),
  .active_tasks_i(rsp_o.active_tasks)
);
